// File: src/capability_table_checker_macros.svh
// assertion macros for the capability table checker
`ifndef CAPABILITY_TABLE_CHECKER_MACROS_SVH
`define CAPABILITY_TABLE_CHECKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CTB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define CTB_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");
`else
`define CTB_ASSERT(lbl, prop)
`define CTB_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

// File: src/ctb_pkg.sv
// package: sizes, codes and word types of the capability table checker
`default_nettype none
package ctb_pkg;

    localparam int CAP_ENTRIES       = 1024;
    localparam int CONTEXTS          = 256;
    localparam int SLOTS_PER_CONTEXT = 32;

    localparam int EIDX_W = $clog2(CAP_ENTRIES);
    localparam int CNT_W  = $clog2(CAP_ENTRIES + 1);
    localparam int CIDX_W = $clog2(CONTEXTS);
    localparam int CCNT_W = $clog2(CONTEXTS + 1);
    localparam int FILL_W = $clog2(SLOTS_PER_CONTEXT + 1);
    localparam int SA_W   = $clog2(CONTEXTS * SLOTS_PER_CONTEXT);

    localparam logic [2:0] M_CREATE   = 3'd0;
    localparam logic [2:0] M_VALIDATE = 3'd1;
    localparam logic [2:0] M_REVOKE   = 3'd2;
    localparam logic [2:0] M_CHK_PERM = 3'd3;
    localparam logic [2:0] M_CHK_ACC  = 3'd4;
    localparam logic [2:0] M_BIND     = 3'd5;
    localparam logic [2:0] M_UNBIND   = 3'd6;
    localparam logic [2:0] M_QUERY    = 3'd7;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_REVOKED   = 3'd3;
    localparam logic [2:0] ST_DENIED    = 3'd4;
    localparam logic [2:0] ST_LIMIT     = 3'd5;
    localparam logic [2:0] ST_BOUND     = 3'd6;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] cap_id;
        logic [31:0] perm_mask;
        logic [31:0] res_type;
        logic [63:0] base_or_addr;
        logic [63:0] extent;
        logic [31:0] need_mask;
        logic [31:0] exec_ctx;
    } ctb_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_id;
        logic [31:0] out_perms;
        logic [31:0] out_type;
    } ctb_out_t;

    typedef struct packed {
        logic        rvk;
        logic [31:0] perms;
        logic [31:0] rtype;
        logic [63:0] base;
        logic [63:0] len;
    } ctb_entry_t;

endpackage
`default_nettype wire

// File: src/ctb_ifs.sv
// request and response channel interfaces
`default_nettype none
interface ctb_in_if
    import ctb_pkg::*;
    ;
    logic    valid;
    logic    ready;
    ctb_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ctb_out_if
    import ctb_pkg::*;
    ;
    logic     valid;
    logic     ready;
    ctb_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/ctb_bounds.sv
// exact 65-bit bounds test for an access against a stored resource
`default_nettype none
module ctb_bounds
    import ctb_pkg::*;
(
    input  wire logic [63:0] addr,
    input  wire logic [63:0] ext,
    input  wire logic [63:0] base,
    input  wire logic [63:0] len,
    output logic             deny
);
    logic [64:0] acc_end;
    logic [64:0] res_end;

    // sums carried one bit wider so that nothing wraps
    assign acc_end = {1'b0, addr} + {1'b0, ext};
    assign res_end = {1'b0, base} + {1'b0, len};
    assign deny    = (addr < base) || (acc_end > res_end);
endmodule
`default_nettype wire

// File: src/capability_table_checker.sv
// capability table checker: one request word in, one response word out per operation.
// create, validate and the checks go from dispatch straight to the response stage;
// bind, unbind and query first compare the context keys one by one, then give up or read
// the fill, walk the list slots (query also checks each entry) and stop at the list end;
// closing up a list moves each later slot down one place; revoke walks every open list.
// one operation at a time, accepted only while idle; reset clears counters and control only.
`default_nettype none
`include "capability_table_checker_macros.svh"
module capability_table_checker
    import ctb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ctb_in_if.sink    req,
    ctb_out_if.source rsp
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_CK_RD   = 4'd2;
    localparam logic [3:0] S_CK_CMP  = 4'd3;
    localparam logic [3:0] S_FILL_RD = 4'd4;
    localparam logic [3:0] S_FILL    = 4'd5;
    localparam logic [3:0] S_LRD     = 4'd6;
    localparam logic [3:0] S_LCMP    = 4'd7;
    localparam logic [3:0] S_QCHK    = 4'd8;
    localparam logic [3:0] S_SRD     = 4'd9;
    localparam logic [3:0] S_SWR     = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;

    // memories
    ctb_entry_t        ent_mem  [CAP_ENTRIES];
    logic [31:0]       key_mem  [CONTEXTS];
    logic [FILL_W-1:0] fill_mem [CONTEXTS];
    logic [CNT_W-1:0]  slot_mem [CONTEXTS * SLOTS_PER_CONTEXT];

    ctb_entry_t        ent_rd_reg;
    logic [31:0]       key_rd_reg;
    logic [FILL_W-1:0] fill_rd_reg;
    logic [CNT_W-1:0]  slot_rd_reg;

    // control and working registers
    logic [3:0]        state_reg, state_next;
    ctb_in_t           item_reg;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CCNT_W-1:0] cused_reg, cused_next;
    logic [CCNT_W-1:0] c_reg, c_next;
    logic [FILL_W-1:0] n_reg, n_next;
    logic [FILL_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0]  sid_reg, sid_next;
    logic [2:0]        st_reg, st_next;
    logic [15:0]       oid_reg, oid_next;
    logic [31:0]       operm_reg, operm_next;
    logic [31:0]       otype_reg, otype_next;
    logic              out_valid_reg;
    ctb_out_t          out_data_reg;

    // memory port controls
    logic              ent_we;
    logic [EIDX_W-1:0] ent_waddr, ent_raddr;
    ctb_entry_t        ent_wdata;
    logic              key_we;
    logic [CIDX_W-1:0] key_waddr;
    logic              fill_we;
    logic [CIDX_W-1:0] fill_waddr;
    logic [FILL_W-1:0] fill_wdata;
    logic              slot_we;
    logic [SA_W-1:0]   slot_waddr, slot_raddr;
    logic [CNT_W-1:0]  slot_wdata;

    logic [CIDX_W-1:0] cidx;
    logic [CIDX_W-1:0] cnew;
    logic              accept;
    logic              tok_present;
    logic [2:0]        tok_st;
    logic              acc_deny;
    logic              load_out;
    logic              slot_match;
    logic              q_present;

    function automatic logic [SA_W-1:0] slot_at(input logic [CIDX_W-1:0] c,
                                                input logic [FILL_W-1:0] j);
        slot_at = SA_W'(c) * SA_W'(SLOTS_PER_CONTEXT) + SA_W'(j);
    endfunction

    assign cidx   = c_reg[CIDX_W-1:0];
    assign cnew   = cused_reg[CIDX_W-1:0];
    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign load_out  = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // token match against the entry read for the request id
    assign tok_present = (item_reg.cap_id != 16'd0) && (item_reg.cap_id <= 16'(used_reg));
    always_comb
    begin
        if (!tok_present)
            tok_st = ST_NOT_FOUND;
        else if (ent_rd_reg.perms != item_reg.perm_mask || ent_rd_reg.rtype != item_reg.res_type)
            tok_st = ST_INVALID;
        else if (ent_rd_reg.rvk)
            tok_st = ST_REVOKED;
        else
            tok_st = ST_OK;
    end

    ctb_bounds u_bounds (
        .addr (item_reg.base_or_addr),
        .ext  (item_reg.extent),
        .base (ent_rd_reg.base),
        .len  (ent_rd_reg.len),
        .deny (acc_deny)
    );

    assign slot_match = (16'(slot_rd_reg) == item_reg.cap_id);
    assign q_present  = (sid_reg != '0) && (sid_reg <= used_reg);

    // read addresses
    always_comb
    begin
        if (state_reg == S_LCMP)
            ent_raddr = EIDX_W'(slot_rd_reg - 1'b1);
        else
            ent_raddr = EIDX_W'(req.data.cap_id - 16'd1);
        if (state_reg == S_SRD)
            slot_raddr = slot_at(cidx, FILL_W'(j_reg + 1'b1));
        else
            slot_raddr = slot_at(cidx, j_reg);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        cused_next = cused_reg;
        c_next     = c_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        sid_next   = sid_reg;
        st_next    = st_reg;
        oid_next   = oid_reg;
        operm_next = operm_reg;
        otype_next = otype_reg;
        ent_we     = 1'b0;
        ent_waddr  = EIDX_W'(item_reg.cap_id - 16'd1);
        ent_wdata  = ent_rd_reg;
        key_we     = 1'b0;
        key_waddr  = cnew;
        fill_we    = 1'b0;
        fill_waddr = cidx;
        fill_wdata = FILL_W'(n_reg - 1'b1);
        slot_we    = 1'b0;
        slot_waddr = slot_at(cidx, j_reg);
        slot_wdata = slot_rd_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    st_next    = ST_OK;
                    oid_next   = 16'd0;
                    operm_next = 32'd0;
                    otype_next = 32'd0;
                    c_next     = '0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_FIN;
                unique case (item_reg.mode)
                    M_CREATE:
                    begin
                        if (used_reg >= CNT_W'(CAP_ENTRIES))
                            st_next = ST_LIMIT;
                        else if (item_reg.res_type == 32'd0 || item_reg.perm_mask == 32'd0)
                            st_next = ST_INVALID;
                        else
                        begin
                            ent_we          = 1'b1;
                            ent_waddr       = used_reg[EIDX_W-1:0];
                            ent_wdata.rvk   = 1'b0;
                            ent_wdata.perms = item_reg.perm_mask;
                            ent_wdata.rtype = item_reg.res_type;
                            ent_wdata.base  = item_reg.base_or_addr;
                            ent_wdata.len   = item_reg.extent;
                            used_next       = CNT_W'(used_reg + 1'b1);
                            oid_next        = 16'(used_reg) + 16'd1;
                        end
                    end
                    M_VALIDATE:
                        st_next = tok_st;
                    M_REVOKE:
                    begin
                        if (!tok_present)
                            st_next = ST_NOT_FOUND;
                        else
                        begin
                            ent_we        = 1'b1;
                            ent_wdata.rvk = 1'b1;
                            if (cused_reg != '0)
                                state_next = S_FILL_RD;
                        end
                    end
                    M_CHK_PERM, M_CHK_ACC:
                    begin
                        if (tok_st != ST_OK)
                            st_next = tok_st;
                        else if ((item_reg.perm_mask & item_reg.need_mask) != item_reg.need_mask)
                            st_next = ST_DENIED;
                        else if (item_reg.mode == M_CHK_ACC && acc_deny)
                            st_next = ST_DENIED;
                    end
                    M_BIND:
                    begin
                        if (item_reg.exec_ctx == 32'd0)
                            st_next = ST_INVALID;
                        else if (tok_st != ST_OK)
                            st_next = tok_st;
                        else
                            state_next = S_CK_RD;
                    end
                    M_UNBIND, M_QUERY:
                        state_next = S_CK_RD;
                    default:
                        state_next = S_FIN;
                endcase
            end
            S_CK_RD:
            begin
                if (c_reg >= cused_reg)
                begin
                    state_next = S_FIN;
                    if (item_reg.mode != M_BIND)
                        st_next = ST_NOT_FOUND;
                    else if (cused_reg >= CCNT_W'(CONTEXTS))
                        st_next = ST_LIMIT;
                    else
                    begin
                        // open a new list holding just this id
                        key_we     = 1'b1;
                        fill_we    = 1'b1;
                        fill_waddr = cnew;
                        fill_wdata = FILL_W'(1);
                        slot_we    = 1'b1;
                        slot_waddr = slot_at(cnew, '0);
                        slot_wdata = CNT_W'(item_reg.cap_id);
                        cused_next = CCNT_W'(cused_reg + 1'b1);
                    end
                end
                else
                    state_next = S_CK_CMP;
            end
            S_CK_CMP:
            begin
                if (key_rd_reg == item_reg.exec_ctx)
                    state_next = S_FILL_RD;
                else
                begin
                    c_next     = CCNT_W'(c_reg + 1'b1);
                    state_next = S_CK_RD;
                end
            end
            S_FILL_RD:
                state_next = S_FILL;
            S_FILL:
            begin
                n_next     = fill_rd_reg;
                j_next     = '0;
                state_next = S_LRD;
            end
            S_LRD:
            begin
                if (j_reg >= n_reg)
                begin
                    state_next = S_FIN;
                    priority case (item_reg.mode)
                        M_BIND:
                        begin
                            if (n_reg >= FILL_W'(SLOTS_PER_CONTEXT))
                                st_next = ST_LIMIT;
                            else
                            begin
                                slot_we    = 1'b1;
                                slot_waddr = slot_at(cidx, n_reg);
                                slot_wdata = CNT_W'(item_reg.cap_id);
                                fill_we    = 1'b1;
                                fill_wdata = FILL_W'(n_reg + 1'b1);
                            end
                        end
                        M_REVOKE:
                        begin
                            // next context list
                            c_next = CCNT_W'(c_reg + 1'b1);
                            if (CCNT_W'(c_reg + 1'b1) < cused_reg)
                                state_next = S_FILL_RD;
                        end
                        default:
                            st_next = ST_NOT_FOUND;
                    endcase
                end
                else
                    state_next = S_LCMP;
            end
            S_LCMP:
            begin
                priority case (item_reg.mode)
                    M_BIND:
                    begin
                        if (slot_match)
                        begin
                            st_next    = ST_BOUND;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            j_next     = FILL_W'(j_reg + 1'b1);
                            state_next = S_LRD;
                        end
                    end
                    M_QUERY:
                    begin
                        sid_next   = slot_rd_reg;
                        state_next = S_QCHK;
                    end
                    default:
                    begin
                        if (slot_match)
                            state_next = S_SRD;
                        else
                        begin
                            j_next     = FILL_W'(j_reg + 1'b1);
                            state_next = S_LRD;
                        end
                    end
                endcase
            end
            S_QCHK:
            begin
                if (q_present && ent_rd_reg.rtype == item_reg.res_type && !ent_rd_reg.rvk)
                begin
                    st_next    = ST_OK;
                    oid_next   = 16'(sid_reg);
                    operm_next = ent_rd_reg.perms;
                    otype_next = ent_rd_reg.rtype;
                    state_next = S_FIN;
                end
                else
                begin
                    j_next     = FILL_W'(j_reg + 1'b1);
                    state_next = S_LRD;
                end
            end
            S_SRD:
            begin
                if (FILL_W'(j_reg + 1'b1) < n_reg)
                    state_next = S_SWR;
                else
                begin
                    // list closed up, one shorter
                    fill_we = 1'b1;
                    if (item_reg.mode == M_REVOKE)
                    begin
                        c_next = CCNT_W'(c_reg + 1'b1);
                        if (CCNT_W'(c_reg + 1'b1) < cused_reg)
                            state_next = S_FILL_RD;
                        else
                            state_next = S_FIN;
                    end
                    else
                        state_next = S_FIN;
                end
            end
            S_SWR:
            begin
                slot_we    = 1'b1;
                j_next     = FILL_W'(j_reg + 1'b1);
                state_next = S_SRD;
            end
            S_FIN:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            cused_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            cused_reg <= cused_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req.data;
        c_reg     <= c_next;
        n_reg     <= n_next;
        j_reg     <= j_next;
        sid_reg   <= sid_next;
        st_reg    <= st_next;
        oid_reg   <= oid_next;
        operm_reg <= operm_next;
        otype_reg <= otype_next;
        if (load_out)
        begin
            out_data_reg.status    <= st_reg;
            out_data_reg.out_id    <= oid_reg;
            out_data_reg.out_perms <= operm_reg;
            out_data_reg.out_type  <= otype_reg;
        end
    end

    // entry table
    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        ent_rd_reg <= ent_mem[ent_raddr];
    end

    // context keys
    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[key_waddr] <= item_reg.exec_ctx;
        key_rd_reg <= key_mem[cidx];
    end

    // list fill counts
    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[fill_waddr] <= fill_wdata;
        fill_rd_reg <= fill_mem[cidx];
    end

    // list slots
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_rd_reg <= slot_mem[slot_raddr];
    end

    // assertions
    `CTB_ASSERT_NEXT(a_accept_busy, accept, state_reg != S_IDLE)
    `CTB_ASSERT(a_used_bound, used_reg <= CNT_W'(CAP_ENTRIES))
    `CTB_ASSERT(a_ctx_bound, cused_reg <= CCNT_W'(CONTEXTS))
    `CTB_ASSERT_NEXT(a_fin_hold, state_reg == S_FIN && out_valid_reg && !rsp.ready,
        state_reg == S_FIN)
endmodule
`default_nettype wire

// File: verif/ctb_checker.sv
// response checker: predicts every response word from the accepted requests and compares
`default_nettype none
module ctb_checker
    import ctb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ctb_in_if         req,
    ctb_out_if        rsp,
    output int        fails,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the capability table and the context lists
    logic [31:0] cap_perms [CAP_ENTRIES];
    logic [31:0] cap_type  [CAP_ENTRIES];
    logic [63:0] cap_base  [CAP_ENTRIES];
    logic [63:0] cap_len   [CAP_ENTRIES];
    logic        cap_gone  [CAP_ENTRIES];
    int          caps_made;
    logic [31:0] ctx_tag   [CONTEXTS];
    int          ctxs_open;
    logic [15:0] bound_ids [CONTEXTS][SLOTS_PER_CONTEXT];
    int          bound_cnt [CONTEXTS];

    ctb_out_t    expected_rsp_q[$];

    assign pending = expected_rsp_q.size();

    function automatic bit cap_present(logic [15:0] id);
        return id != 0 && int'(id) <= caps_made;
    endfunction

    function automatic logic [2:0] token_status(logic [15:0] id, logic [31:0] perms,
                                                logic [31:0] rtype);
        int e;
        if (!cap_present(id))
            return ST_NOT_FOUND;
        e = int'(id) - 1;
        if (cap_perms[e] != perms || cap_type[e] != rtype)
            return ST_INVALID;
        if (cap_gone[e])
            return ST_REVOKED;
        return ST_OK;
    endfunction

    function automatic int find_ctx(logic [31:0] key);
        for (int i = 0; i < ctxs_open; i++)
            if (ctx_tag[i] == key)
                return i;
        return -1;
    endfunction

    // remove first occurrence of id from list c, order kept
    function automatic bit drop_bound(int c, logic [15:0] id);
        for (int j = 0; j < bound_cnt[c]; j++) begin
            if (bound_ids[c][j] == id) begin
                for (int k = j; k + 1 < bound_cnt[c]; k++)
                    bound_ids[c][k] = bound_ids[c][k + 1];
                bound_cnt[c]--;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic ctb_out_t predict_response(ctb_in_t w);
        ctb_out_t   r;
        int         e;
        int         c;
        logic [64:0] acc_end;
        logic [64:0] cap_end;
        r = '0;
        r.status = ST_OK;
        case (w.mode)
            M_CREATE:
            begin
                if (caps_made >= CAP_ENTRIES)
                    r.status = ST_LIMIT;
                else if (w.res_type == 0 || w.perm_mask == 0)
                    r.status = ST_INVALID;
                else
                begin
                    cap_perms[caps_made] = w.perm_mask;
                    cap_type[caps_made]  = w.res_type;
                    cap_base[caps_made]  = w.base_or_addr;
                    cap_len[caps_made]   = w.extent;
                    cap_gone[caps_made]  = 1'b0;
                    caps_made++;
                    r.out_id = 16'(caps_made);
                end
            end
            M_VALIDATE:
                r.status = token_status(w.cap_id, w.perm_mask, w.res_type);
            M_REVOKE:
            begin
                if (!cap_present(w.cap_id))
                    r.status = ST_NOT_FOUND;
                else
                begin
                    cap_gone[int'(w.cap_id) - 1] = 1'b1;
                    for (int i = 0; i < ctxs_open; i++)
                        void'(drop_bound(i, w.cap_id));
                end
            end
            M_CHK_PERM, M_CHK_ACC:
            begin
                r.status = token_status(w.cap_id, w.perm_mask, w.res_type);
                if (r.status == ST_OK && (w.perm_mask & w.need_mask) != w.need_mask)
                    r.status = ST_DENIED;
                if (r.status == ST_OK && w.mode == M_CHK_ACC)
                begin
                    // exact 65-bit bounds
                    e = int'(w.cap_id) - 1;
                    acc_end = {1'b0, w.base_or_addr} + {1'b0, w.extent};
                    cap_end = {1'b0, cap_base[e]} + {1'b0, cap_len[e]};
                    if (w.base_or_addr < cap_base[e] || acc_end > cap_end)
                        r.status = ST_DENIED;
                end
            end
            M_BIND:
            begin
                if (w.exec_ctx == 0)
                    r.status = ST_INVALID;
                else
                begin
                    r.status = token_status(w.cap_id, w.perm_mask, w.res_type);
                    if (r.status == ST_OK)
                    begin
                        c = find_ctx(w.exec_ctx);
                        if (c < 0 && ctxs_open >= CONTEXTS)
                            r.status = ST_LIMIT;
                        else
                        begin
                            // a newly opened list stays open even if the bind fails
                            if (c < 0)
                            begin
                                c = ctxs_open;
                                ctx_tag[c] = w.exec_ctx;
                                bound_cnt[c] = 0;
                                ctxs_open++;
                            end
                            for (int i = 0; i < bound_cnt[c]; i++)
                                if (bound_ids[c][i] == w.cap_id)
                                    r.status = ST_BOUND;
                            if (r.status == ST_OK && bound_cnt[c] >= SLOTS_PER_CONTEXT)
                                r.status = ST_LIMIT;
                            if (r.status == ST_OK)
                            begin
                                bound_ids[c][bound_cnt[c]] = w.cap_id;
                                bound_cnt[c]++;
                            end
                        end
                    end
                end
            end
            M_UNBIND:
            begin
                c = find_ctx(w.exec_ctx);
                if (c < 0 || !drop_bound(c, w.cap_id))
                    r.status = ST_NOT_FOUND;
            end
            default:
            begin
                // first active id of matching type, in list order
                r.status = ST_NOT_FOUND;
                c = find_ctx(w.exec_ctx);
                if (c >= 0)
                begin
                    for (int i = 0; i < bound_cnt[c]; i++)
                    begin
                        e = int'(bound_ids[c][i]) - 1;
                        if (cap_present(bound_ids[c][i]) && cap_type[e] == w.res_type &&
                            !cap_gone[e])
                        begin
                            r.status    = ST_OK;
                            r.out_id    = bound_ids[c][i];
                            r.out_perms = cap_perms[e];
                            r.out_type  = cap_type[e];
                            break;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fails++;
    endtask

    // watch both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        ctb_out_t want;
        if (!rst_n)
        begin
            caps_made = 0;
            ctxs_open = 0;
            fails     = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_rsp_q.push_back(predict_response(req.data));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp_q.size() == 0)
                    report("unexpected word, status", 32'(rsp.data.status), 0);
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.data.status != want.status)
                        report("status", 32'(rsp.data.status), 32'(want.status));
                    if (rsp.data.out_id != want.out_id)
                        report("out_id", 32'(rsp.data.out_id), 32'(want.out_id));
                    if (rsp.data.out_perms != want.out_perms)
                        report("out_perms", rsp.data.out_perms, want.out_perms);
                    if (rsp.data.out_type != want.out_type)
                        report("out_type", rsp.data.out_type, want.out_type);
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: verif/tb.sv
// testbench top: clock, reset, request stimulus, response stalls and verdict
`default_nettype none
module tb
    import ctb_pkg::*;
    ;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;
    bit   calm;

    ctb_in_if  req ();
    ctb_out_if rsp ();

    capability_table_checker dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));
    ctb_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
                     .fails(fails), .pending(pending));

    // tokens this side has created, id = index + 1
    logic [31:0] tok_perms[$];
    logic [31:0] tok_type[$];
    logic [63:0] tok_base[$];
    logic [63:0] tok_len[$];

    initial
        clk = 1'b0;

    always
        #1 clk = ~clk;

    // response stalls
    always @(posedge clk)
        rsp.ready <= rst_n && (calm || $urandom_range(99) >= 21);

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send(ctb_in_t w);
        while (!calm && $urandom_range(99) < 21)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= w;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    function automatic ctb_in_t op(logic [2:0] m, logic [15:0] id, logic [31:0] ctx);
        ctb_in_t w;
        w = '0;
        w.mode = m;
        w.cap_id = id;
        w.exec_ctx = ctx;
        if (id != 0 && int'(id) <= tok_perms.size())
        begin
            w.perm_mask = tok_perms[id - 1];
            w.res_type  = tok_type[id - 1];
        end
        return w;
    endfunction

    task automatic make_cap(logic [31:0] perms, logic [31:0] rtype,
                            logic [63:0] base, logic [63:0] len);
        ctb_in_t w;
        w = op(M_CREATE, 0, 0);
        w.perm_mask = perms;
        w.res_type = rtype;
        w.base_or_addr = base;
        w.extent = len;
        if (perms != 0 && rtype != 0 && tok_perms.size() < CAP_ENTRIES)
        begin
            tok_perms.push_back(perms);
            tok_type.push_back(rtype);
            tok_base.push_back(base);
            tok_len.push_back(len);
        end
        send(w);
    endtask

    task automatic send_random();
        ctb_in_t     w;
        logic [2:0]  m;
        logic [63:0] off;
        logic [63:0] room;
        int          k;
        m = 3'($urandom_range(7));
        if (m == M_CREATE && tok_perms.size() > 300)
            m = M_BIND;
        if (m == M_CREATE)
        begin
            make_cap(($urandom_range(19) == 0) ? 32'h0 : $urandom,
                     ($urandom_range(19) == 0) ? 32'h0 :
                     ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(1, 3)),
                     ($urandom_range(9) == 0) ? '1 : rand64(),
                     ($urandom_range(9) == 0) ? '1 : 64'($urandom_range(0, 4096)));
            return;
        end
        // mostly a known token, sometimes noise
        if (tok_perms.size() > 0 && $urandom_range(99) < 85)
            w = op(m, 16'($urandom_range(1, tok_perms.size())), 0);
        else
        begin
            w = op(m, 16'($urandom), 0);
            w.perm_mask = $urandom;
            w.res_type = $urandom;
        end
        if ($urandom_range(99) < 10)
            w.perm_mask = w.perm_mask ^ (32'h1 << $urandom_range(31));
        if ($urandom_range(99) < 8)
            w.res_type = $urandom;
        w.need_mask = ($urandom_range(99) < 70) ? (w.perm_mask & $urandom) : $urandom;
        w.exec_ctx = ($urandom_range(99) < 85) ? 32'($urandom_range(1, 4)) :
                     ($urandom_range(1) == 0) ? 32'h0 : $urandom;
        if (m == M_QUERY && $urandom_range(1) == 0)
            w.res_type = 32'($urandom_range(1, 3));
        w.base_or_addr = rand64();
        w.extent = rand64();
        // access window inside or just outside the token's range
        if (w.cap_id != 0 && int'(w.cap_id) <= tok_perms.size() && $urandom_range(99) < 75)
        begin
            k = int'(w.cap_id) - 1;
            off = (tok_len[k] == '1) ? rand64() : rand64() % (tok_len[k] + 1);
            room = tok_len[k] - off;
            w.base_or_addr = tok_base[k] + off;
            w.extent = (room == '1) ? rand64() : rand64() % (room + 1);
            case ($urandom_range(9))
                0: w.extent = room + 1;
                1: w.base_or_addr = tok_base[k] - 1;
                default: ;
            endcase
        end
        send(w);
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        calm = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        rsp.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: invalid creates, field extremes, each operation and error path
        make_cap(32'h1, 32'h0, 64'h0, 64'h0);
        make_cap(32'h0, 32'h1, 64'h0, 64'h0);
        make_cap('1, '1, '1, '1);
        make_cap(32'h3, 32'h1, 64'h1000, 64'h100);
        send(op(M_VALIDATE, 2, 0));
        send(op(M_VALIDATE, 0, 0));
        send(op(M_VALIDATE, 3, 0));
        begin
            ctb_in_t w;
            w = op(M_CHK_PERM, 2, 0);
            w.need_mask = 32'h4;
            send(w);
            w = op(M_CHK_ACC, 2, 0);
            w.need_mask = 32'h1;
            w.base_or_addr = 64'h1000;
            w.extent = 64'h100;
            send(w);
            w.base_or_addr = 64'hfff;
            send(w);
            w.base_or_addr = 64'h1001;
            send(w);
            // sums at the top of the 65-bit range
            w = op(M_CHK_ACC, 1, 0);
            w.need_mask = '1;
            w.base_or_addr = '1;
            w.extent = '1;
            send(w);
            w = op(M_VALIDATE, 2, 0);
            w.perm_mask = 32'h7;
            send(w);
        end
        send(op(M_BIND, 2, 0));
        send(op(M_BIND, 2, 7));
        send(op(M_BIND, 2, 7));
        send(op(M_BIND, 1, 7));
        begin
            ctb_in_t w;
            w = op(M_QUERY, 0, 7);
            w.res_type = 32'h1;
            send(w);
        end
        send(op(M_UNBIND, 2, 7));
        send(op(M_UNBIND, 2, 7));
        send(op(M_REVOKE, 1, 0));
        send(op(M_REVOKE, 1, 0));
        send(op(M_VALIDATE, 1, 0));
        send(op(M_QUERY, 0, 99));

        // random part, with a stretch of no stalls and a drain in the middle
        for (int i = 0; i < 60; i++)
        begin
            calm = (i >= 20 && i < 40);
            if (i == 45)
            begin
                req.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            send_random();
        end
        calm = 1'b0;

        // open every context list and one more, with no stalls
        make_cap(32'h5, 32'h2, 64'h0, 64'h10);
        n = tok_perms.size();
        calm = 1'b1;
        for (int k = 0; k <= CONTEXTS; k++)
            send(op(M_BIND, 16'(n), 32'(1000 + k)));
        calm = 1'b0;

        // fill the table, then create past its end
        while (tok_perms.size() < CAP_ENTRIES)
            make_cap($urandom | 32'h1, 32'($urandom_range(1, 3)), rand64(), rand64());
        make_cap(32'h1, 32'h1, 64'h0, 64'h0);
        make_cap(32'h0, 32'h0, 64'h0, 64'h0);
        for (int i = 0; i < 20; i++)
            send_random();
        send(op(M_REVOKE, 16'(n), 0));
        send(op(M_VALIDATE, 16'(CAP_ENTRIES), 0));

        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
